// ===== sv/ttsgr_pkg.sv =====
// shared types, codes and color tables for the text terminal engine
package ttsgr_pkg;

  localparam int unsigned ColW     = 10;
  localparam int unsigned RowW     = 9;
  localparam int unsigned TabW     = 5;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned ArgW     = 14;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned OutW     = 112;

  localparam logic [ColW-1:0]   COLUMNS_RST = 10'd80;
  localparam logic [RowW-1:0]   ROWS_RST    = 9'd25;
  localparam logic [TabW-1:0]   TAB_RST     = 5'd4;
  localparam logic [ColorW-1:0] FORE_RST    = 32'hFFFF_FFFF;
  localparam logic [ColorW-1:0] BACK_RST    = 32'hFF00_0000;

  localparam logic [ArgW-1:0] ARG_MAX = 14'd9999;

  localparam logic [CfgAddrW-1:0] CFG_COLUMNS      = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_ROWS_COUNT   = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_TAB_WIDTH    = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_DEFAULT_FORE = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_DEFAULT_BACK = 3'd4;

  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_ESC     = 8'd27;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_SGR_END = 8'h6D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [ArgW-1:0] SGR_FG      = 14'd30;
  localparam logic [ArgW-1:0] SGR_FG_DEF  = 14'd39;
  localparam logic [ArgW-1:0] SGR_BG      = 14'd40;
  localparam logic [ArgW-1:0] SGR_BG_DEF  = 14'd49;
  localparam logic [ArgW-1:0] SGR_FG_BRT  = 14'd90;
  localparam logic [ArgW-1:0] SGR_BG_BRT  = 14'd100;

  localparam logic [ColorW-1:0] NORMAL_PAL [8] = '{
    32'hFF00_0000, 32'hFFFF_0000, 32'hFF00_FF00, 32'hFFFF_FF00,
    32'hFF00_00FF, 32'hFFFF_00FF, 32'hFF00_FFFF, 32'hFFFF_FFFF
  };
  localparam logic [ColorW-1:0] BRIGHT_PAL [8] = '{
    32'hFF55_5555, 32'hFFFF_5555, 32'hFF55_FF55, 32'hFFFF_FF55,
    32'hFF55_55FF, 32'hFFFF_55FF, 32'hFF55_FFFF, 32'hFFFF_FFFF
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC
  } state_e;

  // true when code lies in the eight codes starting at base
  function automatic logic sgr_in8(logic [ArgW-1:0] code, logic [ArgW-1:0] base);
    logic [ArgW-1:0] diff;
    diff = code - base;
    return (code >= base) && (diff < 14'd8);
  endfunction

endpackage

// ===== sv/text_terminal_cursor_and_sgr_engine.sv =====
// text terminal cursor, wrap, escape parse and sgr color engine
//
// the slave stream takes one character byte per beat in s_axis_tdata[7:0]; the
// master stream returns one result beat per input byte, packed as listed at the port.
// configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i; the user
// writes it only while idle, the block does not enforce this. index 0 columns,
// 1 rows_count, 2 tab_width, 3 default_fore, 4 default_back. an accepted byte runs
// through a small sequencer: from idle it goes to the execute state, and the result
// is registered once the output register is free. a tab first runs sum mod
// tab_width through a restoring remainder unit, one dividend bit a cycle over 11
// bits, before it executes. a new byte is taken only after the last has executed.
// the result sits in an output register; the next byte is taken while it waits,
// and the execute step holds until the register is free when the receiver stalls.
// reset returns the cursor to the top left corner, clears the parse state and
// loads white on black colors and the default geometry 80 x 25, tab 4.
module text_terminal_cursor_and_sgr_engine
  import ttsgr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // byte_in
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // draw_valid, cell_col, cell_row, glyph_code, fore_color, back_color,
  // scroll_up, cursor_col, cursor_row
  output logic [OutW-1:0]     m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [ColorW-1:0]   cfg_wdata_i
);

  logic [ColW-1:0]   columns_q;
  logic [RowW-1:0]   rows_q;
  logic [TabW-1:0]   tab_q;
  logic [ColorW-1:0] def_fore_q, def_back_q;

  state_e            state_q, state_d;
  logic [ColW-1:0]   cur_col_q, cur_col_d;
  logic [RowW-1:0]   cur_row_q, cur_row_d;
  logic              wrap_q, wrap_d;
  logic              esc_q, esc_d;
  logic              br_q, br_d;
  logic [ArgW-1:0]   arg_q, arg_d;
  logic [ColorW-1:0] fore_q, fore_d;
  logic [ColorW-1:0] back_q, back_d;
  logic [7:0]        byte_q, byte_d;
  logic [ColW:0]     tsum_q, tsum_d;
  logic [TabW-1:0]   rem_q, rem_d;
  logic [3:0]        cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [OutW-1:0]   out_data_q, out_data_d;

  logic [ColW-1:0] ncol;
  logic [RowW-1:0] nrow;
  logic [TabW-1:0] tab;
  logic            in_fire, exec_fire;
  logic [ColW-1:0] clamp_col;
  logic [RowW-1:0] clamp_row;
  logic [TabW:0]   div_t, div_s;
  logic [ColW:0]   wcol;
  logic [RowW:0]   wrow;
  logic            dv, scroll;
  logic [ColW-1:0] dcol;
  logic [RowW-1:0] drow;
  logic [7:0]      glyph;
  logic [ArgW+2:0] arg_next;
  logic [2:0]      pal_idx;

  assign ncol = (columns_q == '0) ? ColW'(1) : columns_q;
  assign nrow = (rows_q == '0) ? RowW'(1) : rows_q;
  assign tab  = (tab_q == '0) ? TabW'(1) : tab_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign clamp_col = (cur_col_q >= ncol) ? (ncol - ColW'(1)) : cur_col_q;
  assign clamp_row = (cur_row_q >= nrow) ? (nrow - RowW'(1)) : cur_row_q;

  // restoring remainder step
  assign div_t = {rem_q, tsum_q[cnt_q]};
  assign div_s = div_t - {1'b0, tab};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q  <= COLUMNS_RST;
      rows_q     <= ROWS_RST;
      tab_q      <= TAB_RST;
      def_fore_q <= FORE_RST;
      def_back_q <= BACK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_COLUMNS:      columns_q  <= cfg_wdata_i[ColW-1:0];
        CFG_ROWS_COUNT:   rows_q     <= cfg_wdata_i[RowW-1:0];
        CFG_TAB_WIDTH:    tab_q      <= cfg_wdata_i[TabW-1:0];
        CFG_DEFAULT_FORE: def_fore_q <= cfg_wdata_i;
        CFG_DEFAULT_BACK: def_back_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      wrap_q      <= 1'b0;
      esc_q       <= 1'b0;
      br_q        <= 1'b0;
      arg_q       <= '0;
      fore_q      <= FORE_RST;
      back_q      <= BACK_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      wrap_q      <= wrap_d;
      esc_q       <= esc_d;
      br_q        <= br_d;
      arg_q       <= arg_d;
      fore_q      <= fore_d;
      back_q      <= back_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    tsum_q     <= tsum_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    wrap_d      = wrap_q;
    esc_d       = esc_q;
    br_d        = br_q;
    arg_d       = arg_q;
    fore_d      = fore_q;
    back_d      = back_q;
    byte_d      = byte_q;
    tsum_d      = tsum_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    wcol        = {1'b0, cur_col_q};
    wrow        = {1'b0, cur_row_q};
    dv          = 1'b0;
    dcol        = '0;
    drow        = '0;
    glyph       = '0;
    scroll      = 1'b0;
    arg_next    = ({3'b0, arg_q} << 3) + ({3'b0, arg_q} << 1)
                + (ArgW+3)'(byte_q - CH_ZERO);
    pal_idx     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          byte_d    = s_axis_tdata;
          cur_col_d = clamp_col;
          cur_row_d = clamp_row;
          tsum_d    = {1'b0, clamp_col} + (ColW+1)'(tab);
          rem_d     = '0;
          cnt_d     = 4'(ColW);
          if (!esc_q && s_axis_tdata == CH_TAB) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_DIV: begin
        rem_d = div_t >= {1'b0, tab} ? div_s[TabW-1:0] : div_t[TabW-1:0];
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
          if (esc_q) begin
            if (!br_q) begin
              if (byte_q == CH_BRACKET) begin
                br_d = 1'b1;
              end else begin
                esc_d = 1'b0;
              end
            end else if (byte_q == CH_SGR_END) begin
              priority if (sgr_in8(arg_q, SGR_FG)) begin
                pal_idx = 3'(arg_q - SGR_FG);
                fore_d  = NORMAL_PAL[pal_idx];
              end else if (arg_q == SGR_FG_DEF) begin
                fore_d = def_fore_q;
              end else if (sgr_in8(arg_q, SGR_BG)) begin
                pal_idx = 3'(arg_q - SGR_BG);
                back_d  = NORMAL_PAL[pal_idx];
              end else if (arg_q == SGR_BG_DEF) begin
                back_d = def_back_q;
              end else if (sgr_in8(arg_q, SGR_FG_BRT)) begin
                pal_idx = 3'(arg_q - SGR_FG_BRT);
                fore_d  = BRIGHT_PAL[pal_idx];
              end else if (sgr_in8(arg_q, SGR_BG_BRT)) begin
                pal_idx = 3'(arg_q - SGR_BG_BRT);
                back_d  = BRIGHT_PAL[pal_idx];
              end else begin
              end
              arg_d = '0;
              br_d  = 1'b0;
              esc_d = 1'b0;
            end else if (byte_q >= CH_ZERO && byte_q <= CH_NINE) begin
              arg_d = (arg_next > (ArgW+3)'(ARG_MAX)) ? ARG_MAX : arg_next[ArgW-1:0];
            end
          end else begin
            priority if (byte_q == CH_ESC) begin
              esc_d = 1'b1;
              br_d  = 1'b0;
              arg_d = '0;
            end else if (byte_q == CH_NL) begin
              if (!(cur_col_q == '0 && wrap_q)) begin
                wcol   = '0;
                wrow   = wrow + (RowW+1)'(1);
                wrap_d = 1'b0;
              end
            end else if (byte_q == CH_TAB) begin
              wcol = tsum_q - (ColW+1)'(rem_q);
            end else if (byte_q == CH_BS) begin
              if (!(cur_col_q == '0 && cur_row_q == '0)) begin
                if (cur_col_q == '0) begin
                  wcol = {1'b0, ncol} - (ColW+1)'(1);
                  wrow = wrow - (RowW+1)'(1);
                end else begin
                  wcol = wcol - (ColW+1)'(1);
                end
                dv   = 1'b1;
                dcol = wcol[ColW-1:0];
                drow = wrow[RowW-1:0];
              end
            end else begin
              dv    = 1'b1;
              dcol  = cur_col_q;
              drow  = cur_row_q;
              glyph = byte_q;
              wcol  = wcol + (ColW+1)'(1);
            end
            if (wcol >= {1'b0, ncol}) begin
              wcol   = '0;
              wrow   = wrow + (RowW+1)'(1);
              wrap_d = 1'b1;
            end
            if (wrow >= {1'b0, nrow}) begin
              wcol   = '0;
              wrow   = {1'b0, nrow} - (RowW+1)'(1);
              scroll = 1'b1;
            end
          end
          cur_col_d   = wcol[ColW-1:0];
          cur_row_d   = wrow[RowW-1:0];
          out_valid_d = 1'b1;
          out_data_d  = {wrow[RowW-1:0], wcol[ColW-1:0], scroll, back_d, fore_d,
                         glyph, drow, dcol, dv};
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_cursor_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> (cur_col_q < ncol) && (cur_row_q < nrow))
    else $error("cursor left the screen after a byte");

  a_blank_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[27:1] == '0))
    else $error("cell fields set without a draw");

  a_scroll_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[92]) |-> (m_axis_tdata[102:93] == '0))
    else $error("scroll without cursor at column zero");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < tab))
    else $error("remainder out of range");

endmodule
